### sv/sync_word_deframer_descrambler_assert.svh
// Assertion helpers shared by the deframer modules.
`ifndef SYNC_WORD_DEFRAMER_DESCRAMBLER_ASSERT_SVH
`define SYNC_WORD_DEFRAMER_DESCRAMBLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/swd_pkg.sv
package swd_pkg;

	// Register map, word index = paddr[3:2]
	typedef enum logic [1:0] {
		RegInvert    = 2'd0,
		RegSyncWord  = 2'd1,
		RegFrameLen  = 2'd2,
		RegThreshold = 2'd3
	} reg_idx_t;

	localparam logic        InvertReset    = 1'b0;
	localparam logic [31:0] SyncWordReset  = 32'd2286184776;
	localparam logic [9:0]  FrameLenReset  = 10'd518;
	localparam logic [9:0]  ThresholdReset = 10'd299;

	// First payload byte index after the header
	localparam logic [9:0] FirstDataIndex = 10'd7;
	// Hard cap on frame size in bytes
	localparam int MaxFrameBytes = 1024;

	typedef struct packed {
		logic        invert_bits;
		logic [31:0] sync_word;
		logic [9:0]  frame_length;
		logic [9:0]  partial_threshold;
	} cfg_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [9:0] byte_index;
		logic       byte_valid;
		logic       frame_end;
		logic       truncated;
	} result_t;

	// Descrambler mask, indexed by byte index mod 64
	localparam logic [7:0] ScrambleTab [64] = '{
		8'h96, 8'h83, 8'h3E, 8'h51, 8'hB1, 8'h49, 8'h08, 8'h98,
		8'h32, 8'h05, 8'h59, 8'h0E, 8'hF9, 8'h44, 8'hC6, 8'h26,
		8'h21, 8'h60, 8'hC2, 8'hEA, 8'h79, 8'h5D, 8'h6D, 8'hA1,
		8'h54, 8'h69, 8'h47, 8'h0C, 8'hDC, 8'hE8, 8'h5C, 8'hF1,
		8'hF7, 8'h76, 8'h82, 8'h7F, 8'h07, 8'h99, 8'hA2, 8'h2C,
		8'h93, 8'h7C, 8'h30, 8'h63, 8'hF5, 8'h10, 8'h2E, 8'h61,
		8'hD0, 8'hBC, 8'hB4, 8'hB6, 8'h06, 8'hAA, 8'hF4, 8'h23,
		8'h78, 8'h6E, 8'h3B, 8'hAE, 8'hBF, 8'h7B, 8'h4C, 8'hC1
	};

endpackage

### sv/swd_apb_regs.sv
module swd_apb_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output swd_pkg::cfg_t cfg
);
	import swd_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_bits       <= InvertReset;
			cfg_q.sync_word         <= SyncWordReset;
			cfg_q.frame_length      <= FrameLenReset;
			cfg_q.partial_threshold <= ThresholdReset;
		end else if (wr_en) begin
			unique case (idx)
				RegInvert:    cfg_q.invert_bits       <= pwdata[0];
				RegSyncWord:  cfg_q.sync_word         <= pwdata;
				RegFrameLen:  cfg_q.frame_length      <= pwdata[9:0];
				RegThreshold: cfg_q.partial_threshold <= pwdata[9:0];
				default:      ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			RegInvert:    prdata = {31'd0, cfg_q.invert_bits};
			RegSyncWord:  prdata = cfg_q.sync_word;
			RegFrameLen:  prdata = {22'd0, cfg_q.frame_length};
			RegThreshold: prdata = {22'd0, cfg_q.partial_threshold};
			default:      prdata = '0;
		endcase
	end

endmodule

### sv/swd_framer.sv
`include "sync_word_deframer_descrambler_assert.svh"

module swd_framer #(
	parameter int SYNC_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             data_bit,
	input  logic             gap,
	input  swd_pkg::cfg_t    cfg,
	output logic             has_result,
	output swd_pkg::result_t result
);
	import swd_pkg::*;

	localparam int FillW   = $clog2(SYNC_BITS + 1);
	localparam int CmpBits = (SYNC_BITS < 32) ? SYNC_BITS : 32;

	// Framer state
	logic [SYNC_BITS-1:0] hist_q, hist_d;
	logic [FillW-1:0]     fill_q, fill_d;
	logic                 in_frame_q, in_frame_d;
	logic [2:0]           pos_q, pos_d;
	logic [7:0]           partial_q, partial_d;
	logic [9:0]           idx_q, idx_d;

	logic                 bit_v;
	logic [SYNC_BITS-1:0] sync_ext;
	logic                 sync_hit;
	logic [7:0]           byte_n;
	logic                 last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q     <= '0;
			fill_q     <= '0;
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			partial_q  <= '0;
			idx_q      <= FirstDataIndex;
		end else if (step) begin
			hist_q     <= hist_d;
			fill_q     <= fill_d;
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			partial_q  <= partial_d;
			idx_q      <= idx_d;
		end
	end

	// Shared terms: corrected bit, sync compare, finished byte and end test
	assign bit_v    = data_bit ^ cfg.invert_bits;
	assign sync_ext = SYNC_BITS'(cfg.sync_word[CmpBits-1:0]);
	assign hist_d   = gap ? hist_q : {hist_q[SYNC_BITS-2:0], bit_v};
	assign sync_hit = (fill_d == FillW'(SYNC_BITS)) && (hist_d == sync_ext);
	assign byte_n   = partial_q | (8'(bit_v) << pos_q);
	assign last_byte = ({3'd0, idx_q} + 13'd1 >= {3'd0, cfg.frame_length}) ||
	                   ({3'd0, idx_q} + 13'd1 >= 13'(MaxFrameBytes)) ||
	                   (idx_q == 10'd1023);

	// Next state and result
	always_comb begin
		fill_d     = fill_q;
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		partial_d  = partial_q;
		idx_d      = idx_q;
		has_result = 1'b0;
		result     = '0;

		if (gap) begin
			// early end only past the threshold, otherwise the gap is dropped
			if (in_frame_q && (idx_q > cfg.partial_threshold)) begin
				has_result        = 1'b1;
				result.byte_index = idx_q;
				result.frame_end  = 1'b1;
				result.truncated  = 1'b1;
				in_frame_d        = 1'b0;
				pos_d             = '0;
				partial_d         = '0;
				idx_d             = FirstDataIndex;
			end
		end else begin
			if (fill_q < FillW'(SYNC_BITS))
				fill_d = fill_q + 1'b1;
			fill_d = (fill_q < FillW'(SYNC_BITS)) ? fill_q + 1'b1 : fill_q;

			if (!in_frame_q) begin
				if (sync_hit) begin
					in_frame_d = 1'b1;
					pos_d      = '0;
					partial_d  = '0;
					idx_d      = FirstDataIndex;
				end
			end else if (pos_q == 3'd7) begin
				// byte complete: descramble with mask at index mod 64
				has_result        = 1'b1;
				result.byte_out   = byte_n ^ ScrambleTab[idx_q[5:0]];
				result.byte_index = idx_q;
				result.byte_valid = 1'b1;
				result.frame_end  = last_byte;
				pos_d             = '0;
				partial_d         = '0;
				if (last_byte) begin
					in_frame_d = 1'b0;
					idx_d      = FirstDataIndex;
				end else begin
					idx_d = idx_q + 10'd1;
				end
			end else begin
				partial_d = byte_n;
				pos_d     = pos_q + 3'd1;
			end
		end
	end

	`SWD_ASSERT_NOW(a_pos_in_frame, clk, arst_n, pos_q != 3'd0, in_frame_q,
		"bit position advanced outside a frame")
	`SWD_ASSERT_NOW(a_idx_idle, clk, arst_n, !in_frame_q, idx_q == FirstDataIndex,
		"byte index not rewound while hunting")
	`SWD_ASSERT_NOW(a_partial_idle, clk, arst_n, !in_frame_q, partial_q == 8'd0,
		"partial byte not cleared while hunting")
	`SWD_ASSERT_NOW(a_fill_sat, clk, arst_n, 1'b1, fill_q <= FillW'(SYNC_BITS),
		"history fill count overran")

endmodule

### sv/sync_word_deframer_descrambler.sv
// Channel   Dir  Payload
// s_axis    in   tdata[0] data_bit, tuser[0] gap
// m_axis    out  tdata[7:0] byte_out, tdata[17:8] byte_index, tuser[0] byte_valid,
//                tuser[1] truncated, tlast frame_end
// apb       in   4 config words at 0x0, 0x4, 0x8, 0xC
//
// One input item per cycle while m_axis is not stalled; an accepted item passes through the input
// register, then framer logic into the result register, where its result is valid.
// arst_n clears the pipeline, the framer state and the config words to their defaults.
// With m_axis_tready low the result holds and one more item can still enter the input
// register; after that s_axis_tready drops until the result is taken.
`include "sync_word_deframer_descrambler_assert.svh"

module sync_word_deframer_descrambler #(
	parameter int SYNC_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] data_bit, [7:1] zero
	input  logic [0:0]  s_axis_tuser,  // [0] gap
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] byte_out, [17:8] byte_index, [23:18] zero
	output logic [1:0]  m_axis_tuser,  // [0] byte_valid, [1] truncated
	output logic        m_axis_tlast,  // frame_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import swd_pkg::*;

	cfg_t    cfg;
	logic    valid_s1, bit_s1, gap_s1;
	logic    adv_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    fr_has;
	result_t fr_res;

	swd_apb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Handshake: stage 1 moves on when the result register is free or draining
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			bit_s1 <= s_axis_tdata[0];
			gap_s1 <= s_axis_tuser[0];
		end
	end

	swd_framer #(
		.SYNC_BITS(SYNC_BITS)
	) u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.data_bit  (bit_s1),
		.gap       (gap_s1),
		.cfg       (cfg),
		.has_result(fr_has),
		.result    (fr_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= fr_has;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && fr_has)
			res_s2 <= fr_res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, res_s2.byte_index, res_s2.byte_out};
	assign m_axis_tuser  = {res_s2.truncated, res_s2.byte_valid};
	assign m_axis_tlast  = res_s2.frame_end;

	`SWD_ASSERT_NOW(a_trunc_flags, clk, arst_n, m_axis_tvalid && m_axis_tuser[1],
		!m_axis_tuser[0] && m_axis_tlast, "truncation result must end frame without a byte")
	`SWD_ASSERT_NOW(a_empty_byte, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tdata[7:0] == 8'd0, "byte field not zero on a result without a byte")
	`SWD_ASSERT_NOW(a_no_overwrite, clk, arst_n, valid_s2 && !m_axis_tready, !adv_s1,
		"stage 1 advanced over a stalled result")
	`SWD_ASSERT_NEXT(a_result_lands, clk, arst_n, adv_s1 && fr_has, m_axis_tvalid,
		"framer result did not reach the output register")

endmodule

### verif/sync_word_deframer_descrambler_test.sv
`timescale 1ns / 100ps

package deframer_check_pkg;
	import swd_pkg::*;

	localparam int HistoryBits = 32;
	localparam int MaskBytes   = 64;
	localparam int LastIndex   = 1023;

	// Descrambler mask, kept apart from the design's own table
	localparam logic [7:0] DescrambleMask [MaskBytes] = '{
		8'h96, 8'h83, 8'h3E, 8'h51, 8'hB1, 8'h49, 8'h08, 8'h98,
		8'h32, 8'h05, 8'h59, 8'h0E, 8'hF9, 8'h44, 8'hC6, 8'h26,
		8'h21, 8'h60, 8'hC2, 8'hEA, 8'h79, 8'h5D, 8'h6D, 8'hA1,
		8'h54, 8'h69, 8'h47, 8'h0C, 8'hDC, 8'hE8, 8'h5C, 8'hF1,
		8'hF7, 8'h76, 8'h82, 8'h7F, 8'h07, 8'h99, 8'hA2, 8'h2C,
		8'h93, 8'h7C, 8'h30, 8'h63, 8'hF5, 8'h10, 8'h2E, 8'h61,
		8'hD0, 8'hBC, 8'hB4, 8'hB6, 8'h06, 8'hAA, 8'hF4, 8'h23,
		8'h78, 8'h6E, 8'h3B, 8'hAE, 8'hBF, 8'h7B, 8'h4C, 8'hC1
	};

	// One input item: a received bit or a gap mark
	typedef struct packed {
		logic data_bit;
		logic gap;
	} rx_symbol_t;

	class deframer_scoreboard;
		cfg_t        cfg;
		logic [31:0] history;
		int unsigned history_fill;
		bit          in_frame;
		logic [2:0]  bit_pos;
		logic [7:0]  byte_acc;
		logic [9:0]  next_index;
		result_t     expected_q[$];
		int unsigned n_errors;
		int unsigned n_symbols;
		int unsigned n_bytes;
		int unsigned n_frame_ends;
		int unsigned n_truncations;

		function new();
			cfg = '{invert_bits: InvertReset, sync_word: SyncWordReset,
				frame_length: FrameLenReset, partial_threshold: ThresholdReset};
			history = '0;
			history_fill = 0;
			n_errors = 0;
			n_symbols = 0;
			n_bytes = 0;
			n_frame_ends = 0;
			n_truncations = 0;
			restart_hunt();
		endfunction

		function void restart_hunt();
			in_frame = 1'b0;
			bit_pos = '0;
			byte_acc = '0;
			next_index = FirstDataIndex;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				RegInvert:    cfg.invert_bits = value[0];
				RegSyncWord:  cfg.sync_word = value;
				RegFrameLen:  cfg.frame_length = value[9:0];
				RegThreshold: cfg.partial_threshold = value[9:0];
				default: ;
			endcase
		endfunction

		// Advance the framer by one accepted item and queue what it should emit
		function void note_input(rx_symbol_t sym);
			logic        b;
			result_t     r;
			int unsigned idx;
			bit          last;
			n_symbols++;
			if (sym.gap) begin
				// gap only counts once the frame is past the threshold
				if (in_frame && next_index > cfg.partial_threshold) begin
					r = '{byte_out: 8'h00, byte_index: next_index, byte_valid: 1'b0,
						frame_end: 1'b1, truncated: 1'b1};
					expected_q.push_back(r);
					restart_hunt();
				end
				return;
			end
			b = sym.data_bit ^ cfg.invert_bits;
			history = {history[30:0], b};
			if (history_fill < HistoryBits)
				history_fill++;
			if (!in_frame) begin
				if (history_fill >= HistoryBits && history == cfg.sync_word) begin
					restart_hunt();
					in_frame = 1'b1;
				end
				return;
			end
			// LSB-first byte assembly
			byte_acc[bit_pos] = b;
			bit_pos++;
			if (bit_pos != 0)
				return;
			idx = 32'(next_index);
			last = (idx + 1 >= cfg.frame_length) || (idx + 1 >= MaxFrameBytes) ||
				(idx >= LastIndex);
			r = '{byte_out: byte_acc ^ DescrambleMask[idx % MaskBytes],
				byte_index: 10'(idx), byte_valid: 1'b1, frame_end: last, truncated: 1'b0};
			expected_q.push_back(r);
			byte_acc = '0;
			if (last)
				restart_hunt();
			else
				next_index = 10'(idx + 1);
		endfunction

		task report(string msg);
			if (n_errors < 200)
				$display("%0t mismatch: %s", $time, msg);
			n_errors++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want, int unsigned index);
			if (got !== want)
				report($sformatf("%s is %0h, expected %0h (byte index %0d)", name, got, want,
					index));
		endtask

		task check_result(result_t got);
			result_t     want;
			int unsigned at;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result: byte %02h index %0d valid %b end %b trunc %b",
					got.byte_out, got.byte_index, got.byte_valid, got.frame_end, got.truncated));
				return;
			end
			want = expected_q.pop_front();
			at = 32'(want.byte_index);
			check_field("byte_out", 32'(got.byte_out), 32'(want.byte_out), at);
			check_field("byte_index", 32'(got.byte_index), 32'(want.byte_index), at);
			check_field("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid), at);
			check_field("frame_end", 32'(got.frame_end), 32'(want.frame_end), at);
			check_field("truncated", 32'(got.truncated), 32'(want.truncated), at);
			n_bytes += 32'(want.byte_valid);
			n_frame_ends += 32'(want.frame_end);
			n_truncations += 32'(want.truncated);
		endtask
	endclass

endpackage

module sync_word_deframer_descrambler_test;
	import swd_pkg::*;
	import deframer_check_pkg::*;

	localparam int IdleLimit     = 2000;
	localparam int HoldOffCycles = 300;
	localparam int PipeDepth     = 2;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [0] data_bit, [7:1] zero
	logic [0:0]  s_axis_tuser = '0;   // [0] gap
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [7:0] byte_out, [17:8] byte_index, [23:18] zero
	logic [1:0]  m_axis_tuser;        // [0] byte_valid, [1] truncated
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	deframer_scoreboard sb;
	rx_symbol_t  symbols_q[$];
	cfg_t        cur_cfg;
	bit          hold_req = 1'b0;
	bit          rx_on = 1'b0;
	int unsigned hold_left = 0;
	int unsigned rx_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned n_settings = 0;

	sync_word_deframer_descrambler u_dut (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Monitor: results are checked before the same edge's input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result('{byte_out: m_axis_tdata[7:0], byte_index: m_axis_tdata[17:8],
					byte_valid: m_axis_tuser[0], frame_end: m_axis_tlast,
					truncated: m_axis_tuser[1]});
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input('{data_bit: s_axis_tdata[0], gap: s_axis_tuser[0]});
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin : watchdog
		wait (arst_n);
		while (idle_cycles < IdleLimit)
			@(posedge clk);
		$display("timeout: nothing moved for %0d cycles, %0d results outstanding",
			idle_cycles, sb.expected_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: alternating ready/stall stretches, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_req && m_axis_tvalid) begin
			hold_req = 1'b0;
			hold_left = HoldOffCycles;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_on = !rx_on;
				if (rx_on)
					rx_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
				else
					rx_left = $urandom_range(1, 8);
			end
			rx_left--;
			m_axis_tready <= rx_on;
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(cfg_t c);
		cur_cfg = c;
		reg_write(RegInvert, {31'd0, c.invert_bits});
		reg_write(RegSyncWord, c.sync_word);
		reg_write(RegFrameLen, {22'd0, c.frame_length});
		reg_write(RegThreshold, {22'd0, c.partial_threshold});
		n_settings++;
	endtask

	function automatic void push_symbol(logic b, logic g);
		symbols_q.push_back('{data_bit: b, gap: g});
	endfunction

	// Raw bits, LSB first
	function automatic void push_bits(logic [31:0] value, int n);
		for (int i = 0; i < n; i++)
			push_symbol(value[i], 1'b0);
	endfunction

	// Sync word as sent on the line, oldest bit first; flip >= 0 corrupts one bit
	function automatic void push_sync(int flip);
		logic b;
		for (int i = 31; i >= 0; i--) begin
			b = cur_cfg.sync_word[i] ^ cur_cfg.invert_bits ^ (i == flip);
			push_symbol(b, 1'b0);
		end
	endfunction

	function automatic void push_payload(int n_bits, int gap_pct);
		for (int i = 0; i < n_bits; i++) begin
			if ($urandom_range(0, 99) < gap_pct)
				push_symbol(1'($urandom), 1'b1);
			push_symbol(1'($urandom), 1'b0);
		end
	endfunction

	// Mostly sync + payload frames; the rest noise, near-miss syncs and gap runs
	function automatic void push_traffic(int n_items);
		int target;
		int kind;
		int full_bits;
		int n;
		target = symbols_q.size() + n_items;
		while (symbols_q.size() < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				if (int'(cur_cfg.frame_length) > int'(FirstDataIndex))
					full_bits = 8 * (int'(cur_cfg.frame_length) - int'(FirstDataIndex));
				else
					full_bits = 8;
				if (full_bits > 480)
					n = $urandom_range(8, 240);
				else if ($urandom_range(0, 9) < 7)
					n = full_bits + $urandom_range(0, 7);
				else
					n = $urandom_range(0, full_bits);
				push_sync(-1);
				push_payload(n, 2);
			end else if (kind < 80) begin
				push_payload($urandom_range(1, 40), 10);
			end else if (kind < 92) begin
				push_sync($urandom_range(0, 31));
				push_payload(8, 0);
			end else begin
				repeat ($urandom_range(1, 4))
					push_symbol(1'($urandom), 1'b1);
			end
		end
	endfunction

	// Sender: bursts of random length with random gaps, sometimes back to back
	task automatic send_all();
		int burst;
		int idle;
		while (symbols_q.size() > 0) begin
			burst = $urandom_range(1, 48);
			while (burst > 0 && symbols_q.size() > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {7'd0, symbols_q[0].data_bit};
				s_axis_tuser <= symbols_q[0].gap;
				void'(symbols_q.pop_front());
				@(posedge clk);
				while (!s_axis_tready)
					@(posedge clk);
				burst--;
			end
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (idle - 1)
					@(negedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain(int settle);
		while (sb.expected_q.size() > 0)
			@(posedge clk);
		repeat (settle)
			@(posedge clk);
	endtask

	task automatic run_phase(cfg_t c, int n_items);
		configure(c);
		push_traffic(n_items);
		send_all();
		drain(PipeDepth + 2);
	endtask

	initial begin
		cfg_t c;
		sb = new();
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// All-zero sync word: match needs a full history; frame length below the header
		configure('{invert_bits: 1'b0, sync_word: 32'h0, frame_length: 10'd0,
			partial_threshold: 10'd7});
		push_symbol(1'b1, 1'b1);        // gap while hunting
		push_bits(32'h0, 31);           // history not yet full
		push_bits(32'h0, 1);            // sync
		push_bits(32'h00, 8);           // single-byte frame, history stays zero
		push_bits(32'h0, 1);            // immediate resync on the next bit
		push_bits(32'hFF, 8);
		send_all();
		drain(PipeDepth + 2);

		// Inverted input; gaps below, at and past the threshold
		configure('{invert_bits: 1'b1, sync_word: 32'hFFFF_FFFF, frame_length: 10'd10,
			partial_threshold: 10'd8});
		push_sync(-1);
		push_symbol(1'b0, 1'b1);        // ignored, count below threshold
		push_bits(32'hA5, 8);
		push_symbol(1'b1, 1'b1);        // still ignored
		push_bits(32'h5A, 8);
		push_symbol(1'b0, 1'b1);        // truncates
		push_sync(-1);
		push_bits($urandom, 24);        // three bytes, last one ends the frame
		send_all();
		drain(PipeDepth + 2);

		// Long frame so the mask index wraps; threshold at max keeps gaps harmless
		configure('{invert_bits: 1'b0, sync_word: SyncWordReset, frame_length: 10'd80,
			partial_threshold: 10'd1023});
		push_sync(-1);
		push_payload(584, 3);
		send_all();
		drain(PipeDepth + 2);

		// Random phases; the first one includes the long receiver hold-off
		hold_req = 1'b1;
		c = '{1'b0, $urandom, 10'($urandom_range(8, 40)), 10'($urandom_range(7, 30))};
		run_phase(c, 250);
		c = '{1'b1, $urandom, 10'd8, 10'd7};
		run_phase(c, 150);
		c = '{1'b0, 32'hFFFF_FFFF, 10'd1023, 10'd7};
		run_phase(c, 200);
		c = '{1'($urandom), $urandom, 10'($urandom_range(0, 7)), 10'($urandom_range(0, 6))};
		run_phase(c, 120);
		repeat (2) begin
			c = '{1'($urandom), $urandom, 10'($urandom_range(8, 60)),
				10'($urandom_range(7, 60))};
			run_phase(c, 140);
		end

		drain(40);
		$display("Run covered %0d bit and gap items under %0d register settings,",
			sb.n_symbols, n_settings);
		$display("with %0d bytes, %0d frame ends and %0d truncations checked.",
			sb.n_bytes, sb.n_frame_ends, sb.n_truncations);
		if (sb.n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/swd_pkg.sv
sv/swd_apb_regs.sv
sv/swd_framer.sv
sv/sync_word_deframer_descrambler.sv
verif/sync_word_deframer_descrambler_test.sv
